// ===== src/mwm_pkg.sv =====
// Shared constants and types for the mecanum wheel mixer.
package mwm_pkg;

    // Fixed-point format of commands and wheel targets.
    localparam int FRAC_BITS = 14;
    localparam int FIELD_W   = 16;
    localparam int ONE_INT   = 1 << FRAC_BITS;

    // Clamped command width: holds a sign-extended field and also +-ONE.
    localparam int CW = (FRAC_BITS + 2 > FIELD_W) ? FRAC_BITS + 2 : FIELD_W;
    // Signed width of a mixed target (sum of three clamped commands).
    localparam int TW = CW + 2;
    // Unsigned width of a target magnitude and of the divisor.
    localparam int MW = TW - 1;
    // Partial remainder width inside the divider.
    localparam int RW = MW + 1;
    // Quotient magnitude width: the quotient never exceeds ONE.
    localparam int QW = FRAC_BITS + 1;
    // Signed width of a scaled wheel command.
    localparam int SW = QW + 1;
    // One divider stage per quotient bit.
    localparam int STAGES = QW;

    // Queue between the front and back parts.
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // Wheel lane order: front-left, front-right, back-left, back-right.
    localparam int LANES = 4;

    // A classified request: target signs, magnitudes and the common divisor.
    typedef struct packed {
        logic [LANES-1:0]         neg;
        logic [LANES-1:0][MW-1:0] mag;
        logic [MW-1:0]            divisor;
    } t_item;

endpackage

// ===== src/mwm_if.sv =====
// Valid/ready channel interfaces for command and wheel requests.
interface mwm_cmd_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] forward_cmd;
    logic signed [15:0] strafe_cmd;
    logic signed [15:0] rotate_cmd;

    modport source (output valid, output forward_cmd, output strafe_cmd,
                    output rotate_cmd, input ready);
    modport sink   (input valid, input forward_cmd, input strafe_cmd,
                    input rotate_cmd, output ready);
endinterface

interface mwm_wheel_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] front_left_out;
    logic signed [15:0] front_right_out;
    logic signed [15:0] back_left_out;
    logic signed [15:0] back_right_out;

    modport source (output valid, output front_left_out, output front_right_out,
                    output back_left_out, output back_right_out, input ready);
    modport sink   (input valid, input front_left_out, input front_right_out,
                    input back_left_out, input back_right_out, output ready);
endinterface

// ===== src/mwm_front.sv =====
// Front part: clamps and mixes commands, then finds the normalization divisor.
module mwm_front import mwm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mwm_cmd_if.sink     i_cmd,
    output logic        o_item_valid,
    output t_item       o_item,
    input  logic        i_item_ready
);

    localparam logic signed [CW-1:0] ONE_C   = CW'(ONE_INT);
    localparam logic signed [CW-1:0] M_ONE_C = -CW'(ONE_INT);
    localparam logic [MW-1:0]        ONE_M   = MW'(ONE_INT);

    logic                           r_s1_vld;
    logic signed [LANES-1:0][TW-1:0] r_t;
    logic                           r_s2_vld;
    t_item                          r_item;

    logic                           s1_load;
    logic                           s2_load;
    logic signed [CW-1:0]           fwd_c;
    logic signed [CW-1:0]           side_c;
    logic signed [CW-1:0]           spin_c;
    logic signed [LANES-1:0][TW-1:0] n_t;
    t_item                          n_item;
    logic [MW-1:0]                  m01;
    logic [MW-1:0]                  m23;
    logic [MW-1:0]                  m_all;

    function automatic logic signed [CW-1:0] clamp_cmd(input logic signed [15:0] x);
        logic signed [CW-1:0] e;
        e = CW'(x);
        if (e > ONE_C) begin
            return ONE_C;
        end else if (e < M_ONE_C) begin
            return M_ONE_C;
        end
        return e;
    endfunction

    // Stage handshake: each stage loads when it is empty or drains in the same cycle.
    assign s2_load     = !r_s2_vld || i_item_ready;
    assign s1_load     = !r_s1_vld || s2_load;
    assign i_cmd.ready = s1_load;

    // Clamp and mix the three commands into four wheel targets.
    always_comb begin
        fwd_c  = clamp_cmd(i_cmd.forward_cmd);
        side_c = clamp_cmd(i_cmd.strafe_cmd);
        spin_c = clamp_cmd(i_cmd.rotate_cmd);
        n_t[0] = TW'(fwd_c) + TW'(side_c) - TW'(spin_c);
        n_t[1] = TW'(fwd_c) - TW'(side_c) + TW'(spin_c);
        n_t[2] = TW'(fwd_c) - TW'(side_c) - TW'(spin_c);
        n_t[3] = TW'(fwd_c) + TW'(side_c) + TW'(spin_c);
    end

    // Take magnitudes, find the largest and pick the divisor.
    always_comb begin
        logic signed [TW-1:0] neg_t;
        for (int k = 0; k < LANES; k++) begin
            neg_t         = -r_t[k];
            n_item.neg[k] = r_t[k][TW-1];
            n_item.mag[k] = r_t[k][TW-1] ? neg_t[MW-1:0] : r_t[k][MW-1:0];
        end
        m01   = (n_item.mag[0] > n_item.mag[1]) ? n_item.mag[0] : n_item.mag[1];
        m23   = (n_item.mag[2] > n_item.mag[3]) ? n_item.mag[2] : n_item.mag[3];
        m_all = (m01 > m23) ? m01 : m23;
        // Dividing by ONE leaves an unscaled target exactly as it is.
        n_item.divisor = (m_all > ONE_M) ? m_all : ONE_M;
    end

    // Stage valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            if (s1_load) begin
                r_s1_vld <= i_cmd.valid;
            end
            if (s2_load) begin
                r_s2_vld <= r_s1_vld;
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_t <= n_t;
        end
        if (s2_load) begin
            r_item <= n_item;
        end
    end

    assign o_item_valid = r_s2_vld;
    assign o_item       = r_item;

`ifndef SYNTHESIS
    a_mag_within_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_vld |-> (r_item.mag[0] <= r_item.divisor) && (r_item.mag[1] <= r_item.divisor)
                  && (r_item.mag[2] <= r_item.divisor) && (r_item.mag[3] <= r_item.divisor))
        else $error("target magnitude exceeds divisor");
`endif

endmodule

// ===== src/mwm_queue.sv =====
// Short queue that decouples the front part from the divider pipeline.
module mwm_queue import mwm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push_valid,
    input  t_item i_push_item,
    output logic  o_push_ready,
    output logic  o_pop_valid,
    output t_item o_pop_item,
    input  logic  i_pop
);

    t_item           r_slot [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr;
    logic [Q_AW:0]   r_count;

    logic            push;
    logic            pop;

    assign o_push_ready = (r_count != (Q_AW+1)'(Q_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_pop_valid;
    assign o_pop_item   = r_slot[r_rd_ptr];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Storage slots.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= i_push_item;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (Q_AW+1)'(Q_DEPTH))
        else $error("queue count beyond depth");
    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not follow a push");
`endif

endmodule

// ===== src/mwm_back.sv =====
// Back part: pipelined restoring divider that scales all four targets.
module mwm_back import mwm_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_item_valid,
    input  t_item        i_item,
    output logic         o_pop,
    mwm_wheel_if.source  o_wheel
);

    localparam logic [QW-1:0] ONE_Q = QW'(ONE_INT);

    logic [STAGES-1:0]                       r_vld;
    logic [STAGES-1:0][LANES-1:0][RW-1:0]    r_rem;
    logic [STAGES-1:0][LANES-1:0][QW-1:0]    r_q;
    logic [STAGES-1:0][LANES-1:0]            r_neg;
    logic [STAGES-1:0][MW-1:0]               r_div;
    logic                                    r_out_vld;
    logic [LANES-1:0][15:0]                  r_out;

    logic                                    en;
    logic [LANES-1:0][15:0]                  n_out;

    function automatic logic [15:0] fit16(input logic signed [SW-1:0] v);
        logic signed [SW+15:0] e;
        e = (SW+16)'(v);
        return e[15:0];
    endfunction

    // The whole pipeline advances while the output register is free or drains.
    assign en    = !r_out_vld || o_wheel.ready;
    assign o_pop = en && i_item_valid;

    // One quotient bit per stage, four lanes side by side.
    for (genvar j = 0; j < STAGES; j++) begin : g_stage
        logic [LANES-1:0][RW-1:0] rem_in;
        logic [LANES-1:0][QW-1:0] q_in;
        logic [LANES-1:0]         neg_in;
        logic [MW-1:0]            div_in;
        logic                     vld_in;
        logic [LANES-1:0][RW-1:0] n_rem;
        logic [LANES-1:0][QW-1:0] n_q;

        if (j == 0) begin : g_head
            always_comb begin
                for (int k = 0; k < LANES; k++) begin
                    rem_in[k] = {1'b0, i_item.mag[k]};
                    q_in[k]   = '0;
                end
                neg_in = i_item.neg;
                div_in = i_item.divisor;
                vld_in = i_item_valid;
            end
        end else begin : g_body
            always_comb begin
                rem_in = r_rem[j-1];
                q_in   = r_q[j-1];
                neg_in = r_neg[j-1];
                div_in = r_div[j-1];
                vld_in = r_vld[j-1];
            end
        end

        // Compare-and-subtract, then shift the partial remainder.
        always_comb begin
            logic          bit_q;
            logic [RW-1:0] diff;
            logic [RW-1:0] kept;
            for (int k = 0; k < LANES; k++) begin
                diff     = rem_in[k] - {1'b0, div_in};
                bit_q    = (rem_in[k] >= {1'b0, div_in});
                kept     = bit_q ? diff : rem_in[k];
                n_rem[k] = {kept[MW-1:0], 1'b0};
                n_q[k]   = {q_in[k][QW-2:0], bit_q};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (en) begin
                r_vld[j] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_rem[j] <= n_rem;
                r_q[j]   <= n_q;
                r_neg[j] <= neg_in;
                r_div[j] <= div_in;
            end
        end
    end

    // Restore the sign; the quotient was taken on magnitudes, so it truncates toward zero.
    always_comb begin
        logic signed [SW-1:0] pos;
        for (int k = 0; k < LANES; k++) begin
            pos      = $signed({1'b0, r_q[STAGES-1][k]});
            n_out[k] = r_neg[STAGES-1][k] ? fit16(-pos) : fit16(pos);
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_vld[STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_wheel.valid           = r_out_vld;
    assign o_wheel.front_left_out  = r_out[0];
    assign o_wheel.front_right_out = r_out[1];
    assign o_wheel.back_left_out   = r_out[2];
    assign o_wheel.back_right_out  = r_out[3];

`ifndef SYNTHESIS
    a_quot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[STAGES-1] |-> (r_q[STAGES-1][0] <= ONE_Q) && (r_q[STAGES-1][1] <= ONE_Q)
                         && (r_q[STAGES-1][2] <= ONE_Q) && (r_q[STAGES-1][3] <= ONE_Q))
        else $error("scaled wheel command above one");
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld))
        else $error("divider pipeline moved during a stall");
`endif

endmodule

// ===== src/mecanum_wheel_mixer_core.sv =====
// Mecanum wheel mixer: clamp, mix and normalize drive commands into wheel commands.
// Takes one command request per cycle unless the output side stalls, and returns one
// wheel request for each, in order. A command passes two front stages (clamp and mix,
// then magnitude and divisor), a queue slot, FRAC_BITS + 1 divider stages that each
// settle one quotient bit for all four wheels, and the output register. Throughput is
// one request per cycle while the output side is ready. A four-entry queue lets the
// front keep accepting while the output side stalls.
module mecanum_wheel_mixer_core import mwm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mwm_cmd_if.sink     i_cmd,
    mwm_wheel_if.source o_wheel
);

    logic  front_valid;
    t_item front_item;
    logic  push_ready;
    logic  pop_valid;
    t_item pop_item;
    logic  pop;

    // Classification of each command.
    mwm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (i_cmd),
        .o_item_valid (front_valid),
        .o_item       (front_item),
        .i_item_ready (push_ready)
    );

    // Decoupling queue.
    mwm_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .i_push_item  (front_item),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_item   (pop_item),
        .i_pop        (pop)
    );

    // Scaling and output.
    mwm_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (pop_valid),
        .i_item       (pop_item),
        .o_pop        (pop),
        .o_wheel      (o_wheel)
    );

endmodule

// ===== test/wheel_mix_checker.sv =====
// Checker that predicts wheel requests from accepted commands and compares them in order.
`timescale 1ns / 1ps
module wheel_mix_checker import mwm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mwm_cmd_if          i_cmd,
    mwm_wheel_if        i_wheel,
    output int          o_mismatch_count,
    output int          o_outstanding
);

    // One set of wheel commands, in lane order.
    typedef struct {
        logic signed [15:0] fl;
        logic signed [15:0] fr;
        logic signed [15:0] bl;
        logic signed [15:0] br;
    } t_wheel_set;

    t_wheel_set expected_wheels[$];
    int         mismatch_count = 0;
    int         outstanding    = 0;

    assign o_mismatch_count = mismatch_count;
    assign o_outstanding    = outstanding;

    // Saturate a command to the +-1.0 range.
    function automatic longint saturate_cmd(input logic signed [15:0] cmd);
        longint unit;
        longint v;
        unit = longint'(1) << FRAC_BITS;
        v    = longint'(cmd);
        if (v > unit) begin
            return unit;
        end
        if (v < -unit) begin
            return -unit;
        end
        return v;
    endfunction

    // Mix the three commands into four wheel targets and normalize to +-1.0.
    function automatic t_wheel_set mix_wheels(input logic signed [15:0] fwd,
                                              input logic signed [15:0] side,
                                              input logic signed [15:0] spin);
        longint     unit;
        longint     f;
        longint     s;
        longint     r;
        longint     tgt[4];
        longint     peak;
        longint     m;
        t_wheel_set w;
        unit = longint'(1) << FRAC_BITS;
        f = saturate_cmd(fwd);
        s = saturate_cmd(side);
        r = saturate_cmd(spin);
        tgt[0] = f + s - r;
        tgt[1] = f - s + r;
        tgt[2] = f - s - r;
        tgt[3] = f + s + r;
        peak = 0;
        for (int i = 0; i < 4; i++) begin
            m = (tgt[i] < 0) ? -tgt[i] : tgt[i];
            if (m > peak) begin
                peak = m;
            end
        end
        // Division of signed integers truncates toward zero.
        if (peak > unit) begin
            for (int i = 0; i < 4; i++) begin
                tgt[i] = (tgt[i] * unit) / peak;
            end
        end
        w.fl = tgt[0][15:0];
        w.fr = tgt[1][15:0];
        w.bl = tgt[2][15:0];
        w.br = tgt[3][15:0];
        return w;
    endfunction

    // Print one mismatch line and count it.
    task automatic flag_mismatch(input string note);
        $display("ERROR at %0t: %s", $realtime, note);
        mismatch_count++;
    endtask

    task automatic check_lane(input string lane, input logic signed [15:0] got,
                              input logic signed [15:0] want);
        if (got !== want) begin
            flag_mismatch($sformatf("%s got %0d, expected %0d", lane, got, want));
        end
    endtask

    // Compare each accepted wheel request with the oldest prediction, then
    // record a prediction for each accepted command request.
    always @(posedge i_clk) begin : compare
        t_wheel_set want;
        if (i_rst_n) begin
            if (i_wheel.valid && i_wheel.ready) begin
                if (expected_wheels.size() == 0) begin
                    flag_mismatch($sformatf("wheel request with nothing pending (fl %0d)",
                                            i_wheel.front_left_out));
                end else begin
                    want = expected_wheels.pop_front();
                    check_lane("front_left_out",  i_wheel.front_left_out,  want.fl);
                    check_lane("front_right_out", i_wheel.front_right_out, want.fr);
                    check_lane("back_left_out",   i_wheel.back_left_out,   want.bl);
                    check_lane("back_right_out",  i_wheel.back_right_out,  want.br);
                end
            end
            if (i_cmd.valid && i_cmd.ready) begin
                expected_wheels.push_back(mix_wheels(i_cmd.forward_cmd, i_cmd.strafe_cmd,
                                                     i_cmd.rotate_cmd));
            end
            outstanding = expected_wheels.size();
        end
    end

endmodule

// ===== test/testbench.sv =====
// Top of the mecanum wheel mixer testbench: clock, reset, command stimulus and verdict.
`timescale 1ns / 1ps
module testbench import mwm_pkg::*; ();

    localparam int                 RANDOM_CMDS = 450;
    localparam logic signed [15:0] CMD_MAX     = 16'sh7fff;
    localparam logic signed [15:0] CMD_MIN     = 16'sh8000;
    localparam logic signed [15:0] UNIT        = 16'(ONE_INT);
    localparam logic signed [15:0] HALF        = 16'(ONE_INT / 2);
    localparam int                 LONG_HOLD   = 100;
    localparam int                 SETTLE      = 40;

    logic i_clk;
    logic i_rst_n;
    int   mismatch_count;
    int   wheels_outstanding;

    mwm_cmd_if   cmd_ch();
    mwm_wheel_if wheel_ch();

    mecanum_wheel_mixer_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_wheel (wheel_ch)
    );

    wheel_mix_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd_ch),
        .i_wheel          (wheel_ch),
        .o_mismatch_count (mismatch_count),
        .o_outstanding    (wheels_outstanding)
    );

    // 8 ns clock.
    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // Hard stop in case the block hangs.
    initial begin
        #2_000_000;
        $display("testbench NOT OK");
        $finish;
    end

    // Pick one command value: mostly in range, some around the saturation
    // point, some tiny, some anywhere in the 16-bit field.
    function automatic logic signed [15:0] rand_cmd();
        int v;
        case ($urandom_range(0, 9))
            0, 1: begin
                v = int'($urandom_range(0, 65535));
            end
            2, 3: begin
                v = ONE_INT + int'($urandom_range(0, 8)) - 4;
                if ($urandom_range(0, 1) == 1) begin
                    v = -v;
                end
            end
            4: begin
                v = int'($urandom_range(0, 64)) - 32;
            end
            default: begin
                v = int'($urandom_range(0, 2 * ONE_INT)) - ONE_INT;
            end
        endcase
        return v[15:0];
    endfunction

    // Offer one command request and hold it until it is accepted.
    // Called and returns at a falling edge.
    task automatic offer_cmd(input logic signed [15:0] fwd, input logic signed [15:0] side,
                             input logic signed [15:0] spin);
        cmd_ch.valid       = 1'b1;
        cmd_ch.forward_cmd = fwd;
        cmd_ch.strafe_cmd  = side;
        cmd_ch.rotate_cmd  = spin;
        @(posedge i_clk);
        while (!cmd_ch.ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    // Leave the command channel idle with junk on the payload.
    task automatic idle_cmd(input int cycles);
        cmd_ch.valid = 1'b0;
        cmd_ch.forward_cmd = 16'($urandom_range(0, 65535));
        cmd_ch.strafe_cmd  = 16'($urandom_range(0, 65535));
        cmd_ch.rotate_cmd  = 16'($urandom_range(0, 65535));
        repeat (cycles) @(negedge i_clk);
    endtask

    // Stop sending until every predicted wheel request has come back.
    task automatic drain_wheels();
        cmd_ch.valid = 1'b0;
        while (wheels_outstanding != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Output side: phases of steady, random, sparse and alternating ready,
    // with a long hold-off every sixth phase so the block backs up.
    initial begin : wheel_sink
        int phase;
        int mode;
        int len;
        wheel_ch.ready = 1'b0;
        phase = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (phase % 6 == 2) begin
                wheel_ch.ready = 1'b0;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
            end else begin
                mode = $urandom_range(0, 3);
                len  = $urandom_range(20, 80);
                for (int c = 0; c < len; c++) begin
                    case (mode)
                        0: wheel_ch.ready = 1'b1;
                        1: wheel_ch.ready = ($urandom_range(0, 1) == 1);
                        2: wheel_ch.ready = ($urandom_range(0, 3) == 0);
                        default: wheel_ch.ready = c[0];
                    endcase
                    if (c != len - 1) begin
                        @(negedge i_clk);
                    end
                end
            end
            phase++;
        end
    end

    // Command stimulus and verdict.
    initial begin : cmd_source
        int  sent;
        int  burst;
        bit  drained;
        cmd_ch.valid       = 1'b0;
        cmd_ch.forward_cmd = '0;
        cmd_ch.strafe_cmd  = '0;
        cmd_ch.rotate_cmd  = '0;
        i_rst_n            = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: zero, single axes, saturation, the exact-unity boundary
        // and just above it, mixed extremes and odd divisors.
        offer_cmd(16'sd0, 16'sd0, 16'sd0);
        offer_cmd(UNIT, 16'sd0, 16'sd0);
        offer_cmd(-UNIT, 16'sd0, 16'sd0);
        offer_cmd(16'sd0, UNIT, 16'sd0);
        offer_cmd(16'sd0, 16'sd0, -UNIT);
        offer_cmd(CMD_MAX, 16'sd0, 16'sd0);
        offer_cmd(CMD_MIN, 16'sd0, 16'sd0);
        offer_cmd(16'sd0, CMD_MAX, CMD_MIN);
        offer_cmd(UNIT + 16'sd1, -UNIT - 16'sd1, UNIT + 16'sd1);
        offer_cmd(CMD_MAX, CMD_MAX, CMD_MAX);
        offer_cmd(CMD_MIN, CMD_MIN, CMD_MIN);
        offer_cmd(CMD_MAX, CMD_MIN, CMD_MAX);
        offer_cmd(HALF, HALF, 16'sd0);
        offer_cmd(HALF, HALF, 16'sd1);
        offer_cmd(16'sd1, 16'sd1, 16'sd1);
        offer_cmd(-16'sd1, -16'sd1, -16'sd1);
        offer_cmd(16'sd12345, -16'sd7001, 16'sd3333);
        offer_cmd(UNIT, UNIT, 16'sd0);
        offer_cmd(16'sd0, -UNIT, UNIT);
        offer_cmd(16'sh5555, 16'shaaaa, 16'sh0f0f);
        offer_cmd(UNIT - 16'sd1, UNIT - 16'sd1, UNIT - 16'sd1);
        drain_wheels();

        // Random bursts with random gaps; one full drain halfway through.
        sent    = 0;
        drained = 1'b0;
        while (sent < RANDOM_CMDS) begin
            burst = $urandom_range(1, 16);
            for (int b = 0; b < burst && sent < RANDOM_CMDS; b++) begin
                offer_cmd(rand_cmd(), rand_cmd(), rand_cmd());
                sent++;
            end
            if (!drained && sent >= RANDOM_CMDS / 2) begin
                drain_wheels();
                drained = 1'b1;
            end
            if ($urandom_range(0, 3) != 0) begin
                idle_cmd($urandom_range(1, 8));
            end
        end

        // Let every wheel request return, then allow the pipeline to settle.
        cmd_ch.valid = 1'b0;
        drain_wheels();
        repeat (SETTLE) @(posedge i_clk);
        if (mismatch_count == 0 && wheels_outstanding == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
